/* rtl/ami_pkg.sv */
// Shared types and constants for the affine 3x4 matrix inverse.
// Used by the channel interfaces, the front pipeline, the divider cells and the top level.
`default_nettype none
package ami_pkg;

    localparam int N_ELEM  = 12;
    localparam int N_MINOR = 9;
    localparam int ELEM_W  = 32;
    localparam int MINOR_W = 64;
    // determinant and translation sums are below 3 * 2^94 in magnitude
    localparam int SUM_W   = 98;
    localparam int DEN_W   = 96;
    // numerators stay below 2^120, the divisor shifted by 32 below 2^128
    localparam int REM_W   = 128;
    // bit 32 of a quotient flags an out-of-range result
    localparam int QUO_W   = 33;

    localparam logic [ELEM_W-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [ELEM_W-1:0] SAT_NEG = 32'h8000_0000;

    typedef logic [N_ELEM-1:0][ELEM_W-1:0] elem_vec_t;

    typedef struct packed {
        logic                               zero;
        logic [DEN_W-1:0]                   den;
        logic [N_ELEM-1:0]                  neg;
        logic [N_ELEM-1:0][REM_W-1:0]       rem;
        logic [N_ELEM-1:0][QUO_W-1:0]       quo;
    } div_bus_t;

endpackage
`default_nettype wire

/* rtl/ami_if.sv */
// Valid/ready channel interfaces for the matrix and its inverse.
// Depends on ami_pkg for the element width.
`default_nettype none
interface ami_in_if;
    logic                             valid;
    logic                             ready;
    logic signed [ami_pkg::ELEM_W-1:0] in_r0c0;
    logic signed [ami_pkg::ELEM_W-1:0] in_r0c1;
    logic signed [ami_pkg::ELEM_W-1:0] in_r0c2;
    logic signed [ami_pkg::ELEM_W-1:0] in_r0c3;
    logic signed [ami_pkg::ELEM_W-1:0] in_r1c0;
    logic signed [ami_pkg::ELEM_W-1:0] in_r1c1;
    logic signed [ami_pkg::ELEM_W-1:0] in_r1c2;
    logic signed [ami_pkg::ELEM_W-1:0] in_r1c3;
    logic signed [ami_pkg::ELEM_W-1:0] in_r2c0;
    logic signed [ami_pkg::ELEM_W-1:0] in_r2c1;
    logic signed [ami_pkg::ELEM_W-1:0] in_r2c2;
    logic signed [ami_pkg::ELEM_W-1:0] in_r2c3;

    modport source (
        output valid, in_r0c0, in_r0c1, in_r0c2, in_r0c3, in_r1c0, in_r1c1, in_r1c2,
               in_r1c3, in_r2c0, in_r2c1, in_r2c2, in_r2c3,
        input  ready
    );
    modport sink (
        input  valid, in_r0c0, in_r0c1, in_r0c2, in_r0c3, in_r1c0, in_r1c1, in_r1c2,
               in_r1c3, in_r2c0, in_r2c1, in_r2c2, in_r2c3,
        output ready
    );
endinterface

interface ami_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [ami_pkg::ELEM_W-1:0] out_r0c0;
    logic signed [ami_pkg::ELEM_W-1:0] out_r0c1;
    logic signed [ami_pkg::ELEM_W-1:0] out_r0c2;
    logic signed [ami_pkg::ELEM_W-1:0] out_r0c3;
    logic signed [ami_pkg::ELEM_W-1:0] out_r1c0;
    logic signed [ami_pkg::ELEM_W-1:0] out_r1c1;
    logic signed [ami_pkg::ELEM_W-1:0] out_r1c2;
    logic signed [ami_pkg::ELEM_W-1:0] out_r1c3;
    logic signed [ami_pkg::ELEM_W-1:0] out_r2c0;
    logic signed [ami_pkg::ELEM_W-1:0] out_r2c1;
    logic signed [ami_pkg::ELEM_W-1:0] out_r2c2;
    logic signed [ami_pkg::ELEM_W-1:0] out_r2c3;

    modport source (
        output valid, out_r0c0, out_r0c1, out_r0c2, out_r0c3, out_r1c0, out_r1c1,
               out_r1c2, out_r1c3, out_r2c0, out_r2c1, out_r2c2, out_r2c3,
        input  ready
    );
    modport sink (
        input  valid, out_r0c0, out_r0c1, out_r0c2, out_r0c3, out_r1c0, out_r1c1,
               out_r1c2, out_r1c3, out_r2c0, out_r2c1, out_r2c2, out_r2c3,
        output ready
    );
endinterface
`default_nettype wire

/* rtl/ami_front.sv */
// Six-stage front pipeline: minors, determinant, translation sums and divider set-up.
// Depends on ami_pkg for widths and the divider bus type.
`default_nettype none
module ami_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ami_pkg::elem_vec_t in_elem,
    output logic               out_valid,
    input  logic               out_ready,
    output ami_pkg::div_bus_t  out_bus
);

    localparam int NSTG    = 6;
    localparam int N_ELEM  = ami_pkg::N_ELEM;
    localparam int N_MINOR = ami_pkg::N_MINOR;
    localparam int MINOR_W = ami_pkg::MINOR_W;
    localparam int SUM_W   = ami_pkg::SUM_W;
    localparam int DEN_W   = ami_pkg::DEN_W;
    localparam int REM_W   = ami_pkg::REM_W;
    localparam int ELEM_W  = ami_pkg::ELEM_W;

    // minor slot r*3+c is a[i0]*a[i1] - a[i2]*a[i3]
    localparam int unsigned MIDX [N_MINOR][4] = '{
        '{5, 10, 6, 9}, '{2, 9, 1, 10}, '{1, 6, 2, 5},
        '{6, 8, 4, 10}, '{0, 10, 2, 8}, '{2, 4, 0, 6},
        '{4, 9, 5, 8},  '{1, 8, 0, 9},  '{0, 5, 1, 4}
    };

    logic [NSTG-1:0] v_reg;
    logic [NSTG-1:0] v_next;
    logic [NSTG-1:0] ld;

    always_comb
    begin
        ld[NSTG-1] = !v_reg[NSTG-1] || out_ready;
        for (int k = NSTG - 2; k >= 0; k--)
        begin
            ld[k] = !v_reg[k] || ld[k+1];
        end
    end

    always_comb
    begin
        v_next[0] = ld[0] ? in_valid : v_reg[0];
        for (int k = 1; k < NSTG; k++)
        begin
            v_next[k] = ld[k] ? v_reg[k-1] : v_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign in_ready  = ld[0];
    assign out_valid = v_reg[NSTG-1];

    // stage 1: capture
    ami_pkg::elem_vec_t a_reg;

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            a_reg <= in_elem;
        end
    end

    // stage 2: the two products of each minor
    logic signed [MINOR_W-1:0] pa_next [N_MINOR];
    logic signed [MINOR_W-1:0] pb_next [N_MINOR];
    logic signed [MINOR_W-1:0] pa_reg  [N_MINOR];
    logic signed [MINOR_W-1:0] pb_reg  [N_MINOR];
    logic [ELEM_W-1:0]         dcol2_reg [3];
    logic [ELEM_W-1:0]         tcol2_reg [3];

    always_comb
    begin
        for (int s = 0; s < N_MINOR; s++)
        begin
            pa_next[s] = $signed(a_reg[4'(MIDX[s][0])]) * $signed(a_reg[4'(MIDX[s][1])]);
            pb_next[s] = $signed(a_reg[4'(MIDX[s][2])]) * $signed(a_reg[4'(MIDX[s][3])]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[1])
        begin
            for (int s = 0; s < N_MINOR; s++)
            begin
                pa_reg[s] <= pa_next[s];
                pb_reg[s] <= pb_next[s];
            end
            for (int j = 0; j < 3; j++)
            begin
                dcol2_reg[j] <= a_reg[j];
                tcol2_reg[j] <= a_reg[j*4+3];
            end
        end
    end

    // stage 3: minors
    logic signed [MINOR_W-1:0] minor3_reg [N_MINOR];
    logic [ELEM_W-1:0]         dcol3_reg [3];
    logic [ELEM_W-1:0]         tcol3_reg [3];

    always_ff @(posedge clk)
    begin
        if (ld[2])
        begin
            for (int s = 0; s < N_MINOR; s++)
            begin
                minor3_reg[s] <= pa_reg[s] - pb_reg[s];
            end
            dcol3_reg <= dcol2_reg;
            tcol3_reg <= tcol2_reg;
        end
    end

    // stage 4: minor times column, split at bit 32 of the minor
    // slots 0..8 feed the translation sums, 9..11 the determinant
    logic signed [MINOR_W-1:0] hi_next [N_ELEM];
    logic signed [MINOR_W:0]   lo_next [N_ELEM];
    logic signed [MINOR_W-1:0] hi_reg  [N_ELEM];
    logic signed [MINOR_W:0]   lo_reg  [N_ELEM];
    logic signed [MINOR_W-1:0] minor4_reg [N_MINOR];

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                hi_next[r*3+j] = $signed(minor3_reg[r*3+j][MINOR_W-1:32])
                                 * $signed(tcol3_reg[j]);
                lo_next[r*3+j] = $signed({1'b0, minor3_reg[r*3+j][31:0]})
                                 * $signed(tcol3_reg[j]);
            end
        end
        for (int j = 0; j < 3; j++)
        begin
            hi_next[N_MINOR+j] = $signed(minor3_reg[j*3][MINOR_W-1:32]) * $signed(dcol3_reg[j]);
            lo_next[N_MINOR+j] = $signed({1'b0, minor3_reg[j*3][31:0]}) * $signed(dcol3_reg[j]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[3])
        begin
            for (int p = 0; p < N_ELEM; p++)
            begin
                hi_reg[p] <= hi_next[p];
                lo_reg[p] <= lo_next[p];
            end
            minor4_reg <= minor3_reg;
        end
    end

    // stage 5: determinant and negated translation sums
    logic signed [SUM_W-1:0] term [N_ELEM];
    logic signed [SUM_W-1:0] det_next;
    logic signed [SUM_W-1:0] trans_next [3];
    logic signed [SUM_W-1:0] det_reg;
    logic signed [SUM_W-1:0] trans_reg [3];
    logic signed [MINOR_W-1:0] minor5_reg [N_MINOR];

    always_comb
    begin
        for (int p = 0; p < N_ELEM; p++)
        begin
            term[p] = (SUM_W'(hi_reg[p]) <<< 32) + SUM_W'(lo_reg[p]);
        end
        det_next = term[N_MINOR] + term[N_MINOR+1] + term[N_MINOR+2];
        for (int r = 0; r < 3; r++)
        begin
            trans_next[r] = -(term[r*3] + term[r*3+1] + term[r*3+2]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[4])
        begin
            det_reg    <= det_next;
            trans_reg  <= trans_next;
            minor5_reg <= minor4_reg;
        end
    end

    // stage 6: magnitudes, signs and scaled numerators
    ami_pkg::div_bus_t       bus_next;
    ami_pkg::div_bus_t       bus_reg;
    logic signed [SUM_W-1:0] num;
    logic [SUM_W-1:0]        mag;
    logic [SUM_W-1:0]        dmag;

    always_comb
    begin
        dmag = det_reg[SUM_W-1] ? SUM_W'(-det_reg) : SUM_W'(det_reg);
        num  = '0;
        mag  = '0;
        bus_next.zero = (det_reg == '0);
        bus_next.den  = dmag[DEN_W-1:0];
        bus_next.quo  = '0;
        bus_next.neg  = '0;
        bus_next.rem  = '0;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                if (c == 3)
                begin
                    num = trans_reg[r];
                end
                else
                begin
                    num = SUM_W'(minor5_reg[r*3+c]);
                end
                mag = num[SUM_W-1] ? SUM_W'(-num) : SUM_W'(num);
                bus_next.neg[r*4+c] = num[SUM_W-1] ^ det_reg[SUM_W-1];
                if (c == 3)
                begin
                    bus_next.rem[r*4+c] = REM_W'(mag) << FRAC_BITS;
                end
                else
                begin
                    bus_next.rem[r*4+c] = REM_W'(mag) << (2 * FRAC_BITS);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[5])
        begin
            bus_reg <= bus_next;
        end
    end

    assign out_bus = bus_reg;

endmodule
`default_nettype wire

/* rtl/ami_div_cell.sv */
// One cell of the divider chain: settles quotient bit BIT for all twelve elements.
// Depends on ami_pkg for the divider bus type.
`default_nettype none
module ami_div_cell #(
    parameter int BIT = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ami_pkg::div_bus_t in_bus,
    output logic              out_valid,
    input  logic              out_ready,
    output ami_pkg::div_bus_t out_bus
);

    localparam int REM_W  = ami_pkg::REM_W;
    localparam int N_ELEM = ami_pkg::N_ELEM;

    logic              valid_reg;
    logic              ld;
    logic [REM_W-1:0]  step;
    ami_pkg::div_bus_t bus_next;
    ami_pkg::div_bus_t bus_reg;

    assign ld        = !valid_reg || out_ready;
    assign in_ready  = ld;
    assign out_valid = valid_reg;
    assign out_bus   = bus_reg;

    // restoring step against the divisor shifted to this bit
    always_comb
    begin
        step     = REM_W'(in_bus.den) << BIT;
        bus_next = in_bus;
        for (int e = 0; e < N_ELEM; e++)
        begin
            if (in_bus.rem[e] >= step)
            begin
                bus_next.rem[e]      = in_bus.rem[e] - step;
                bus_next.quo[e][BIT] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ld)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld)
        begin
            bus_reg <= bus_next;
        end
    end

endmodule
`default_nettype wire

/* rtl/affine_matrix_inverse_3x4.sv */
// Affine 3x4 matrix inverse, signed fixed point with FRAC_BITS fraction bits.
// Depends on ami_pkg, ami_in_if / ami_out_if, ami_front and ami_div_cell.
//
// Usage:
//   matrix  : valid/ready sink, twelve signed elements in row order, one transfer
//             per matrix when valid and ready are both high.
//   inverse : valid/ready source, twelve signed elements of the inverse.
//   From transfer in to valid out a matrix passes six front stages (capture,
//   products, minors, column products, sums, set-up), a chain of 33 divider
//   cells that each settle one quotient bit (bit 32 flags overflow), and one
//   output register that saturates and signs the quotients.
//   One matrix per cycle unless the output stalls; each stage holds one matrix.
//   A zero determinant gives the identity matrix.
//   When the receiver stalls, each stage holds only while the stage after it
//   is full, so bubbles close up and ready drops only once the chain is full.
//   Reset clears every stage valid; nothing else needs clearing.
`default_nettype none
module affine_matrix_inverse_3x4 #(
    parameter int FRAC_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    ami_in_if.sink     matrix,
    ami_out_if.source  inverse
);

    localparam int N_ELEM = ami_pkg::N_ELEM;
    localparam int N_CELL = ami_pkg::QUO_W;
    localparam int ELEM_W = ami_pkg::ELEM_W;
    localparam logic [ELEM_W-1:0] ONE = 32'd1 << FRAC_BITS;

    ami_pkg::elem_vec_t elem;

    assign elem[0]  = matrix.in_r0c0;
    assign elem[1]  = matrix.in_r0c1;
    assign elem[2]  = matrix.in_r0c2;
    assign elem[3]  = matrix.in_r0c3;
    assign elem[4]  = matrix.in_r1c0;
    assign elem[5]  = matrix.in_r1c1;
    assign elem[6]  = matrix.in_r1c2;
    assign elem[7]  = matrix.in_r1c3;
    assign elem[8]  = matrix.in_r2c0;
    assign elem[9]  = matrix.in_r2c1;
    assign elem[10] = matrix.in_r2c2;
    assign elem[11] = matrix.in_r2c3;

    logic [N_CELL:0]   cv;
    logic [N_CELL:0]   cr;
    ami_pkg::div_bus_t cb [N_CELL+1];

    ami_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (matrix.valid),
        .in_ready  (matrix.ready),
        .in_elem   (elem),
        .out_valid (cv[0]),
        .out_ready (cr[0]),
        .out_bus   (cb[0])
    );

    genvar i;
    for (i = 0; i < N_CELL; i++)
    begin : g_cell
        ami_div_cell #(
            .BIT (N_CELL - 1 - i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (cv[i]),
            .in_ready  (cr[i]),
            .in_bus    (cb[i]),
            .out_valid (cv[i+1]),
            .out_ready (cr[i+1]),
            .out_bus   (cb[i+1])
        );
    end

    // output register: sign, saturate, or substitute the identity
    logic                            ovalid_reg;
    logic                            ld_out;
    ami_pkg::elem_vec_t              res_next;
    ami_pkg::elem_vec_t              res_reg;
    logic [ELEM_W-1:0]               q;
    logic                            big;

    assign ld_out     = !ovalid_reg || inverse.ready;
    assign cr[N_CELL] = ld_out;

    always_comb
    begin
        q   = '0;
        big = 1'b0;
        for (int e = 0; e < N_ELEM; e++)
        begin
            q   = cb[N_CELL].quo[e][ELEM_W-1:0];
            big = cb[N_CELL].quo[e][ELEM_W];
            if (cb[N_CELL].zero)
            begin
                res_next[e] = (e == 0 || e == 5 || e == 10) ? ONE : '0;
            end
            else if (cb[N_CELL].neg[e])
            begin
                res_next[e] = (big || q > ami_pkg::SAT_NEG) ? ami_pkg::SAT_NEG : -q;
            end
            else
            begin
                res_next[e] = (big || q[ELEM_W-1]) ? ami_pkg::SAT_POS : q;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
        end
        else if (ld_out)
        begin
            ovalid_reg <= cv[N_CELL];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_out)
        begin
            res_reg <= res_next;
        end
    end

    assign inverse.valid    = ovalid_reg;
    assign inverse.out_r0c0 = res_reg[0];
    assign inverse.out_r0c1 = res_reg[1];
    assign inverse.out_r0c2 = res_reg[2];
    assign inverse.out_r0c3 = res_reg[3];
    assign inverse.out_r1c0 = res_reg[4];
    assign inverse.out_r1c1 = res_reg[5];
    assign inverse.out_r1c2 = res_reg[6];
    assign inverse.out_r1c3 = res_reg[7];
    assign inverse.out_r2c0 = res_reg[8];
    assign inverse.out_r2c1 = res_reg[9];
    assign inverse.out_r2c2 = res_reg[10];
    assign inverse.out_r2c3 = res_reg[11];

endmodule
`default_nettype wire
